>>> hw/rtl/gipc_pkg.sv
`default_nettype none
package gipc_pkg;

    // Default grid limits
    localparam int DEF_MAX_ROWS = 16;
    localparam int DEF_MAX_COLS = 16;

    // Field widths
    localparam int VAL_W  = 32;
    localparam int PATH_W = 30;
    localparam int CFG_W  = 5;
    localparam int DIR_W  = 3;

    localparam logic [PATH_W-1:0] PATH_MOD = 30'd1000000007;

    // Register indexes
    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    localparam logic [CFG_W-1:0] SIZE_RESET = 5'd16;

    // Neighbor directions, in walk order
    localparam logic [DIR_W-1:0] DIR_UP    = 3'd0;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd1;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd3;
    localparam logic [DIR_W-1:0] DIR_END   = 3'd4;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CLEAR,
        ST_ORD,
        ST_OCHK,
        ST_STEP,
        ST_NBR,
        ST_POP,
        ST_FIN
    } state_t;

endpackage
`default_nettype wire

>>> hw/rtl/gipc_addmod.sv
`default_nettype none
module gipc_addmod
    import gipc_pkg::*;
(
    input  wire logic [PATH_W-1:0] a,
    input  wire logic [PATH_W-1:0] b,
    output logic      [PATH_W-1:0] y
);

    logic [PATH_W:0] sum;

    // Add, then one conditional subtract of the modulus
    always_comb begin
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= {1'b0, PATH_MOD}) begin
            y = PATH_W'(sum - {1'b0, PATH_MOD});
        end else begin
            y = sum[PATH_W-1:0];
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/gipc_nbr.sv
`default_nettype none
module gipc_nbr
    import gipc_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS,
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int RCW = $clog2(MAX_ROWS + 1),
    localparam int CCW = $clog2(MAX_COLS + 1)
)
(
    input  wire logic [RW-1:0]    row,
    input  wire logic [CW-1:0]    col,
    input  wire logic [DIR_W-1:0] dir,
    input  wire logic [RCW-1:0]   rows,
    input  wire logic [CCW-1:0]   cols,
    output logic      [RW-1:0]    nb_row,
    output logic      [CW-1:0]    nb_col,
    output logic                  nb_ok
);

    // Neighbor coordinates and bounds check
    always_comb begin
        nb_row = row;
        nb_col = col;
        nb_ok  = 1'b0;
        case (dir)
            DIR_UP: begin
                nb_row = RW'(row - 1'b1);
                nb_ok  = (row != '0);
            end
            DIR_DOWN: begin
                nb_row = RW'(row + 1'b1);
                nb_ok  = (int'(row) + 1 < int'(rows));
            end
            DIR_LEFT: begin
                nb_col = CW'(col - 1'b1);
                nb_ok  = (col != '0);
            end
            DIR_RIGHT: begin
                nb_col = CW'(col + 1'b1);
                nb_ok  = (int'(col) + 1 < int'(cols));
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> hw/rtl/grid_increasing_path_counter.sv
`default_nettype none
// Counts strictly increasing paths in a grid of up to MAX_ROWS x MAX_COLS signed
// cells. Cells stream in raster order, one per cycle; after the last cell the block
// clears its memo flags cell by cell, walks every cell with an explicit stack held
// in block memory, and sends one path_total (mod 1000000007). The compute phase
// passes each cell through the outer-loop states ST_ORD and ST_OCHK, and for each
// cell walked takes a step per direction, a neighbor read per in-bounds neighbor,
// a closing step and, but for the walk's root, a pop; its pace is set by the
// memories' single read ports and the one shared modular adder. The input is not
// ready during the compute phase. Writing row_count or col_count restarts the grid.
module grid_increasing_path_counter
    import gipc_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
)
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic             cfg_addr,
    input  wire logic [CFG_W-1:0] cfg_wdata,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [31:0]      s_tdata,   // [31:0] cell_value
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic      [31:0]      m_tdata    // [29:0] path_total, [31:30] zero
);

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int NW    = $clog2(CELLS + 1);
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RCW   = $clog2(MAX_ROWS + 1);
    localparam int CCW   = $clog2(MAX_COLS + 1);
    localparam int MW    = PATH_W + 1;
    localparam int SW    = RW + CW + DIR_W + PATH_W + VAL_W;

    // Registers
    state_t            state_reg, state_next;
    logic [CFG_W-1:0]  row_cfg_reg, col_cfg_reg;
    logic [NW-1:0]     loaded_reg, loaded_next;
    logic [AW-1:0]     k_reg, k_next;
    logic [RW-1:0]     k_row_reg, k_row_next;
    logic [CW-1:0]     k_col_reg, k_col_next;
    logic [NW-1:0]     depth_reg, depth_next;
    logic [RW-1:0]     top_row_reg, top_row_next;
    logic [CW-1:0]     top_col_reg, top_col_next;
    logic [DIR_W-1:0]  top_dir_reg, top_dir_next;
    logic [PATH_W-1:0] top_acc_reg, top_acc_next;
    logic [VAL_W-1:0]  top_val_reg, top_val_next;
    logic [RW-1:0]     nb_row_reg, nb_row_next;
    logic [CW-1:0]     nb_col_reg, nb_col_next;
    logic [PATH_W-1:0] pop_acc_reg, pop_acc_next;
    logic [PATH_W-1:0] total_reg, total_next;
    logic              out_valid_reg, out_valid_next;
    logic [PATH_W-1:0] out_data_reg, out_data_next;

    // Memories
    logic [VAL_W-1:0] cell_mem [CELLS];
    logic [MW-1:0]    cnt_mem  [CELLS];
    logic [SW-1:0]    stk_mem  [CELLS];
    logic [VAL_W-1:0] cell_rd_reg;
    logic [MW-1:0]    cnt_rd_reg;
    logic [SW-1:0]    stk_rd_reg;

    logic             cell_we;
    logic [AW-1:0]    cell_waddr, rd_addr;
    logic             cnt_we;
    logic [AW-1:0]    cnt_waddr;
    logic [MW-1:0]    cnt_wdata;
    logic             stk_we;
    logic [AW-1:0]    stk_waddr, stk_raddr;
    logic [SW-1:0]    stk_wdata;

    // Effective grid size
    logic [RCW-1:0] rows_eff;
    logic [CCW-1:0] cols_eff;
    logic [NW-1:0]  total_cells;

    always_comb begin
        if (row_cfg_reg == '0) begin
            rows_eff = RCW'(1);
        end else if (int'(row_cfg_reg) > MAX_ROWS) begin
            rows_eff = RCW'(MAX_ROWS);
        end else begin
            rows_eff = RCW'(row_cfg_reg);
        end
        if (col_cfg_reg == '0) begin
            cols_eff = CCW'(1);
        end else if (int'(col_cfg_reg) > MAX_COLS) begin
            cols_eff = CCW'(MAX_COLS);
        end else begin
            cols_eff = CCW'(col_cfg_reg);
        end
        total_cells = NW'(NW'(rows_eff) * NW'(cols_eff));
    end

    // Neighbor geometry
    logic [RW-1:0] nbr_row;
    logic [CW-1:0] nbr_col;
    logic          nbr_ok;

    gipc_nbr #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_nbr (
        .row    (top_row_reg),
        .col    (top_col_reg),
        .dir    (top_dir_reg),
        .rows   (rows_eff),
        .cols   (cols_eff),
        .nb_row (nbr_row),
        .nb_col (nbr_col),
        .nb_ok  (nbr_ok)
    );

    logic [AW-1:0] nb_addr, top_addr;
    assign nb_addr  = AW'(NW'(nbr_row) * NW'(cols_eff) + NW'(nbr_col));
    assign top_addr = AW'(NW'(top_row_reg) * NW'(cols_eff) + NW'(top_col_reg));

    // Stack frame read back
    logic [RW-1:0]     stk_row;
    logic [CW-1:0]     stk_col;
    logic [DIR_W-1:0]  stk_dir;
    logic [PATH_W-1:0] stk_acc;
    logic [VAL_W-1:0]  stk_val;
    assign {stk_row, stk_col, stk_dir, stk_acc, stk_val} = stk_rd_reg;

    // Shared modular adder
    logic [PATH_W-1:0] add_a, add_b, add_y;

    always_comb begin
        add_a = total_reg;
        add_b = top_acc_reg;
        case (state_reg)
            ST_OCHK: begin
                add_a = total_reg;
                add_b = cnt_rd_reg[PATH_W-1:0];
            end
            ST_POP: begin
                add_a = stk_acc;
                add_b = pop_acc_reg;
            end
            ST_NBR: begin
                add_a = top_acc_reg;
                add_b = cnt_rd_reg[PATH_W-1:0];
            end
            default: begin
                add_a = total_reg;
                add_b = top_acc_reg;
            end
        endcase
    end

    gipc_addmod u_add (
        .a (add_a),
        .b (add_b),
        .y (add_y)
    );

    logic s_xfer, m_xfer, k_last, nb_greater, top_end, out_free;
    assign s_xfer     = s_tvalid && s_tready;
    assign m_xfer     = m_tvalid && m_tready;
    assign k_last     = (NW'(k_reg) == NW'(total_cells - 1'b1));
    assign nb_greater = ($signed(cell_rd_reg) > $signed(top_val_reg));
    assign top_end    = (top_dir_reg == DIR_END);
    assign out_free   = !out_valid_reg || m_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_xfer && (loaded_reg + 1'b1 >= total_cells)) begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                if (k_last) begin
                    state_next = ST_ORD;
                end
            end
            ST_ORD: begin
                state_next = ST_OCHK;
            end
            ST_OCHK: begin
                if (!cnt_rd_reg[PATH_W]) begin
                    state_next = ST_STEP;
                end else if (k_last) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_ORD;
                end
            end
            ST_STEP: begin
                if (top_end) begin
                    if (depth_reg != NW'(1)) begin
                        state_next = ST_POP;
                    end else if (k_last) begin
                        state_next = ST_FIN;
                    end else begin
                        state_next = ST_ORD;
                    end
                end else if (nbr_ok) begin
                    state_next = ST_NBR;
                end
            end
            ST_NBR: begin
                state_next = ST_STEP;
            end
            ST_POP: begin
                state_next = ST_STEP;
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
        if (cfg_we) begin
            state_next = ST_LOAD;
        end
    end

    // Datapath and memory controls
    always_comb begin
        loaded_next    = loaded_reg;
        k_next         = k_reg;
        k_row_next     = k_row_reg;
        k_col_next     = k_col_reg;
        depth_next     = depth_reg;
        top_row_next   = top_row_reg;
        top_col_next   = top_col_reg;
        top_dir_next   = top_dir_reg;
        top_acc_next   = top_acc_reg;
        top_val_next   = top_val_reg;
        nb_row_next    = nb_row_reg;
        nb_col_next    = nb_col_reg;
        pop_acc_next   = pop_acc_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !m_xfer;
        out_data_next  = out_data_reg;
        cell_we        = 1'b0;
        cell_waddr     = AW'(loaded_reg);
        rd_addr        = k_reg;
        cnt_we         = 1'b0;
        cnt_waddr      = k_reg;
        cnt_wdata      = '0;
        stk_we         = 1'b0;
        stk_waddr      = AW'(depth_reg - 1'b1);
        stk_raddr      = AW'(depth_reg - 2'd2);
        stk_wdata      = {top_row_reg, top_col_reg, top_dir_reg, top_acc_reg, top_val_reg};

        // Outer-loop advance, used when a cell's count is final
        if (((state_reg == ST_OCHK) && cnt_rd_reg[PATH_W])
            || ((state_reg == ST_STEP) && top_end && (depth_reg == NW'(1)))) begin
            total_next = add_y;
            k_next     = AW'(k_reg + 1'b1);
            if (int'(k_col_reg) + 1 >= int'(cols_eff)) begin
                k_col_next = '0;
                k_row_next = RW'(k_row_reg + 1'b1);
            end else begin
                k_col_next = CW'(k_col_reg + 1'b1);
            end
        end

        case (state_reg)
            ST_LOAD: begin
                if (s_xfer) begin
                    cell_we = 1'b1;
                    if (loaded_reg + 1'b1 >= total_cells) begin
                        loaded_next = '0;
                        k_next      = '0;
                        total_next  = '0;
                    end else begin
                        loaded_next = NW'(loaded_reg + 1'b1);
                    end
                end
            end
            ST_CLEAR: begin
                cnt_we    = 1'b1;
                cnt_waddr = k_reg;
                cnt_wdata = '0;
                if (k_last) begin
                    k_next     = '0;
                    k_row_next = '0;
                    k_col_next = '0;
                end else begin
                    k_next = AW'(k_reg + 1'b1);
                end
            end
            ST_ORD: begin
                rd_addr = k_reg;
            end
            ST_OCHK: begin
                if (!cnt_rd_reg[PATH_W]) begin
                    depth_next   = NW'(1);
                    top_row_next = k_row_reg;
                    top_col_next = k_col_reg;
                    top_dir_next = DIR_UP;
                    top_acc_next = PATH_W'(1);
                    top_val_next = cell_rd_reg;
                end
            end
            ST_STEP: begin
                if (top_end) begin
                    cnt_we       = 1'b1;
                    cnt_waddr    = top_addr;
                    cnt_wdata    = {1'b1, top_acc_reg};
                    pop_acc_next = top_acc_reg;
                    stk_raddr    = AW'(depth_reg - 2'd2);
                    if (depth_reg == NW'(1)) begin
                        depth_next = '0;
                    end
                end else begin
                    top_dir_next = DIR_W'(top_dir_reg + 1'b1);
                    rd_addr      = nb_addr;
                    nb_row_next  = nbr_row;
                    nb_col_next  = nbr_col;
                end
            end
            ST_NBR: begin
                if (nb_greater) begin
                    if (cnt_rd_reg[PATH_W]) begin
                        top_acc_next = add_y;
                    end else begin
                        stk_we       = 1'b1;
                        stk_waddr    = AW'(depth_reg - 1'b1);
                        depth_next   = NW'(depth_reg + 1'b1);
                        top_row_next = nb_row_reg;
                        top_col_next = nb_col_reg;
                        top_dir_next = DIR_UP;
                        top_acc_next = PATH_W'(1);
                        top_val_next = cell_rd_reg;
                    end
                end
            end
            ST_POP: begin
                depth_next   = NW'(depth_reg - 1'b1);
                top_row_next = stk_row;
                top_col_next = stk_col;
                top_dir_next = stk_dir;
                top_val_next = stk_val;
                top_acc_next = add_y;
            end
            ST_FIN: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = total_reg;
                end
            end
            default: begin
                loaded_next = loaded_reg;
            end
        endcase

        if (cfg_we) begin
            loaded_next = '0;
        end
    end

    // Memory ports
    always_ff @(posedge aclk) begin
        if (cell_we) begin
            cell_mem[cell_waddr] <= s_tdata;
        end
        cell_rd_reg <= cell_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rd_reg <= cnt_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        stk_rd_reg <= stk_mem[stk_raddr];
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            row_cfg_reg   <= SIZE_RESET;
            col_cfg_reg   <= SIZE_RESET;
            loaded_reg    <= '0;
            depth_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            loaded_reg    <= loaded_next;
            depth_reg     <= depth_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_ROW_COUNT: row_cfg_reg <= cfg_wdata;
                    REG_COL_COUNT: col_cfg_reg <= cfg_wdata;
                    default:       row_cfg_reg <= row_cfg_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        k_reg        <= k_next;
        k_row_reg    <= k_row_next;
        k_col_reg    <= k_col_next;
        top_row_reg  <= top_row_next;
        top_col_reg  <= top_col_next;
        top_dir_reg  <= top_dir_next;
        top_acc_reg  <= top_acc_next;
        top_val_reg  <= top_val_next;
        nb_row_reg   <= nb_row_next;
        nb_col_reg   <= nb_col_next;
        pop_acc_reg  <= pop_acc_next;
        out_data_reg <= out_data_next;
    end

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg};

`ifndef NO_ASSERTIONS
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= total_cells)
        else $error("walk stack deeper than grid");

    a_walk_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STEP || state_reg == ST_NBR || state_reg == ST_POP)
        |-> depth_reg != '0)
        else $error("walk step with empty stack");

    a_total_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[29:0] < PATH_MOD)
        else $error("path total not reduced");
`endif

endmodule
`default_nettype wire
